/* sv/i2cmbe_pkg.sv */
// ----------------------------------------------------------------------------
// i2cmbe_pkg
// Shared types and constants for the I2C master bit engine.
// ----------------------------------------------------------------------------
package i2cmbe_pkg;

  localparam int BITS_PER_BYTE = 8;
  localparam int QDEPTH        = 4;
  localparam int QPTR_W        = $clog2(QDEPTH);
  localparam int QCNT_W        = $clog2(QDEPTH + 1);

  // command opcodes
  localparam logic [1:0] OP_START = 2'd0;
  localparam logic [1:0] OP_STOP  = 2'd1;
  localparam logic [1:0] OP_WRITE = 2'd2;
  localparam logic [1:0] OP_READ  = 2'd3;

  // register indexes
  localparam logic REG_HALF_PERIOD = 1'b0;
  localparam logic REG_POLL_LIMIT  = 1'b1;

  localparam logic [15:0] HALF_PERIOD_RST = 16'd100;
  localparam logic [7:0]  POLL_LIMIT_RST  = 8'd250;

  typedef struct packed {
    logic [15:0] half_period_delay;
    logic [7:0]  ack_poll_limit;
  } cfg_t;

  // one tick after classification
  typedef struct packed {
    logic       is_start;
    logic       is_stop;
    logic       is_write;
    logic       is_read;
    logic [7:0] write_byte;
    logic       rd_ack;
    logic       sda_sample;
  } q_item_t;

endpackage

/* sv/i2cmbe_in_if.sv */
// ----------------------------------------------------------------------------
// i2cmbe_in_if
// Tick channel into the bit engine: command fields and sampled SDA.
// ----------------------------------------------------------------------------
interface i2cmbe_in_if;
  logic       valid;
  logic       ready;
  logic       cmd_valid;
  logic [1:0] opcode;
  logic [7:0] write_byte;
  logic       rd_ack;
  logic       sda_sample;

  modport source (output valid, cmd_valid, opcode, write_byte, rd_ack, sda_sample,
                  input ready);
  modport sink   (input valid, cmd_valid, opcode, write_byte, rd_ack, sda_sample,
                  output ready);
endinterface

/* sv/i2cmbe_out_if.sv */
// ----------------------------------------------------------------------------
// i2cmbe_out_if
// Result channel out of the bit engine: pin levels and status per tick.
// ----------------------------------------------------------------------------
interface i2cmbe_out_if;
  logic       valid;
  logic       ready;
  logic       scl_level;
  logic       sda_release;
  logic       busy_res;
  logic       done_res;
  logic [7:0] read_data;
  logic       ack_failed;

  modport source (output valid, scl_level, sda_release, busy_res, done_res, read_data,
                  ack_failed, input ready);
  modport sink   (input valid, scl_level, sda_release, busy_res, done_res, read_data,
                  ack_failed, output ready);
endinterface

/* sv/i2cmbe_front.sv */
// ----------------------------------------------------------------------------
// i2cmbe_front
// Accepts ticks, decodes the opcode into one-hot command flags, and hands
// the classified item to the queue through a register stage.
// ----------------------------------------------------------------------------
module i2cmbe_front (
  input  logic                clk,
  input  logic                rst_n,
  i2cmbe_in_if.sink           in_if,
  output logic                push_valid,
  input  logic                push_ready,
  output i2cmbe_pkg::q_item_t push_item
);
  import i2cmbe_pkg::*;

  logic    f_valid_r, f_valid_nxt;
  q_item_t f_item_r, f_item_nxt;
  logic    accept;

  assign in_if.ready = !f_valid_r || push_ready;
  assign accept      = in_if.valid && in_if.ready;

  always_comb begin
    f_item_nxt            = f_item_r;
    f_valid_nxt           = f_valid_r && !push_ready;
    if (accept) begin
      f_valid_nxt         = 1'b1;
      f_item_nxt.is_start = in_if.cmd_valid && (in_if.opcode == OP_START);
      f_item_nxt.is_stop  = in_if.cmd_valid && (in_if.opcode == OP_STOP);
      f_item_nxt.is_write = in_if.cmd_valid && (in_if.opcode == OP_WRITE);
      f_item_nxt.is_read  = in_if.cmd_valid && (in_if.opcode == OP_READ);
      f_item_nxt.write_byte = in_if.write_byte;
      f_item_nxt.rd_ack     = in_if.rd_ack;
      f_item_nxt.sda_sample = in_if.sda_sample;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      f_valid_r <= 1'b0;
    end else begin
      f_valid_r <= f_valid_nxt;
    end
    f_item_r <= f_item_nxt;
  end

  assign push_valid = f_valid_r;
  assign push_item  = f_item_r;

endmodule

/* sv/i2cmbe_queue.sv */
// ----------------------------------------------------------------------------
// i2cmbe_queue
// Short FIFO between the front and the engine so each side stalls alone.
// ----------------------------------------------------------------------------
module i2cmbe_queue (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                push_valid,
  output logic                push_ready,
  input  i2cmbe_pkg::q_item_t push_item,
  output logic                pop_valid,
  input  logic                pop_ready,
  output i2cmbe_pkg::q_item_t pop_item
);
  import i2cmbe_pkg::*;

  q_item_t           mem [QDEPTH];
  logic [QPTR_W-1:0] wr_ptr_r, wr_ptr_nxt;
  logic [QPTR_W-1:0] rd_ptr_r, rd_ptr_nxt;
  logic [QCNT_W-1:0] count_r, count_nxt;
  logic              push, pop;

  assign push_ready = (count_r != QCNT_W'(QDEPTH));
  assign pop_valid  = (count_r != '0);
  assign push       = push_valid && push_ready;
  assign pop        = pop_valid && pop_ready;
  assign pop_item   = mem[rd_ptr_r];

  always_comb begin
    wr_ptr_nxt = push ? wr_ptr_r + 1'b1 : wr_ptr_r;
    rd_ptr_nxt = pop  ? rd_ptr_r + 1'b1 : rd_ptr_r;
    count_nxt  = count_r;
    if (push && !pop) begin
      count_nxt = count_r + 1'b1;
    end else if (pop && !push) begin
      count_nxt = count_r - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
    if (push) begin
      mem[wr_ptr_r] <= push_item;
    end
  end

endmodule

/* sv/i2cmbe_engine.sv */
// ----------------------------------------------------------------------------
// i2cmbe_engine
// Bit sequencer: runs one tick per item through the start, stop, write and
// read phases, and registers the pin and status result for the sink.
// ----------------------------------------------------------------------------
module i2cmbe_engine (
  input  logic                clk,
  input  logic                rst_n,
  input  i2cmbe_pkg::cfg_t    cfg,
  input  logic                q_valid,
  output logic                q_ready,
  input  i2cmbe_pkg::q_item_t q_item,
  i2cmbe_out_if.source        out_if
);
  import i2cmbe_pkg::*;

  localparam logic [3:0] PH_IDLE     = 4'd0;
  localparam logic [3:0] PH_START_A  = 4'd1;
  localparam logic [3:0] PH_START_B  = 4'd2;
  localparam logic [3:0] PH_STOP_A   = 4'd3;
  localparam logic [3:0] PH_STOP_B   = 4'd4;
  localparam logic [3:0] PH_WR_SETUP = 4'd5;
  localparam logic [3:0] PH_WR_HIGH  = 4'd6;
  localparam logic [3:0] PH_WR_LOW   = 4'd7;
  localparam logic [3:0] PH_ACK_WAIT = 4'd8;
  localparam logic [3:0] PH_RD_LOW   = 4'd9;
  localparam logic [3:0] PH_RD_HIGH  = 4'd10;
  localparam logic [3:0] PH_RA_LOW   = 4'd11;
  localparam logic [3:0] PH_RA_HIGH  = 4'd12;

  localparam logic [3:0] LAST_BIT = 4'(BITS_PER_BYTE - 1);

  logic [3:0]  phase_r, phase_nxt;
  logic [3:0]  bit_idx_r, bit_idx_nxt;
  logic [15:0] delay_r, delay_nxt;
  logic [7:0]  shift_r, shift_nxt;
  logic [7:0]  poll_r, poll_nxt;
  logic        scl_r, scl_nxt;
  logic        sda_r, sda_nxt;
  logic        ack_choice_r, ack_choice_nxt;
  logic        fail_r, fail_nxt;
  logic [7:0]  rd_hold_r, rd_hold_nxt;
  logic        done;

  logic        o_valid_r;
  logic        o_scl_r, o_sda_r, o_busy_r, o_done_r, o_fail_r;
  logic [7:0]  o_rdata_r;
  logic        step;

  assign q_ready = !o_valid_r || out_if.ready;
  assign step    = q_valid && q_ready;

  always_comb begin
    phase_nxt      = phase_r;
    bit_idx_nxt    = bit_idx_r;
    delay_nxt      = delay_r;
    shift_nxt      = shift_r;
    poll_nxt       = poll_r;
    scl_nxt        = scl_r;
    sda_nxt        = sda_r;
    ack_choice_nxt = ack_choice_r;
    fail_nxt       = fail_r;
    rd_hold_nxt    = rd_hold_r;
    done           = 1'b0;

    if (phase_r == PH_IDLE) begin
      // busy ticks drop any command, so only idle decodes one
      if (q_item.is_start || q_item.is_stop || q_item.is_write || q_item.is_read) begin
        bit_idx_nxt = '0;
        poll_nxt    = '0;
        delay_nxt   = cfg.half_period_delay;
      end
      if (q_item.is_start) begin
        sda_nxt   = 1'b1;
        scl_nxt   = 1'b1;
        phase_nxt = PH_START_A;
      end else if (q_item.is_stop) begin
        sda_nxt   = 1'b0;
        scl_nxt   = 1'b0;
        phase_nxt = PH_STOP_A;
      end else if (q_item.is_write) begin
        fail_nxt  = 1'b0;
        sda_nxt   = q_item.write_byte[7];
        shift_nxt = {q_item.write_byte[6:0], 1'b0};
        phase_nxt = PH_WR_SETUP;
      end else if (q_item.is_read) begin
        ack_choice_nxt = q_item.rd_ack;
        shift_nxt      = '0;
        sda_nxt        = 1'b1;
        scl_nxt        = 1'b0;
        phase_nxt      = PH_RD_LOW;
      end
    end else if (delay_r != '0) begin
      delay_nxt = delay_r - 1'b1;
    end else begin
      delay_nxt = cfg.half_period_delay;
      case (phase_r)
        PH_START_A: begin
          sda_nxt   = 1'b0;
          phase_nxt = PH_START_B;
        end
        PH_START_B: begin
          scl_nxt   = 1'b0;
          phase_nxt = PH_IDLE;
          done      = 1'b1;
        end
        PH_STOP_A: begin
          scl_nxt   = 1'b1;
          sda_nxt   = 1'b1;
          phase_nxt = PH_STOP_B;
        end
        PH_STOP_B: begin
          phase_nxt = PH_IDLE;
          done      = 1'b1;
        end
        PH_WR_SETUP: begin
          scl_nxt   = 1'b1;
          phase_nxt = PH_WR_HIGH;
        end
        PH_WR_HIGH: begin
          scl_nxt   = 1'b0;
          phase_nxt = PH_WR_LOW;
        end
        PH_WR_LOW: begin
          bit_idx_nxt = bit_idx_r + 1'b1;
          if (bit_idx_r < LAST_BIT) begin
            sda_nxt   = shift_r[7];
            shift_nxt = {shift_r[6:0], 1'b0};
            phase_nxt = PH_WR_SETUP;
          end else begin
            sda_nxt   = 1'b1;
            scl_nxt   = 1'b1;
            poll_nxt  = '0;
            phase_nxt = PH_ACK_WAIT;
          end
        end
        PH_ACK_WAIT: begin
          // poll once per tick; hold the delay at zero while waiting
          delay_nxt = delay_r;
          if (!q_item.sda_sample) begin
            scl_nxt   = 1'b0;
            fail_nxt  = 1'b0;
            phase_nxt = PH_IDLE;
            done      = 1'b1;
          end else if (poll_r >= cfg.ack_poll_limit) begin
            fail_nxt  = 1'b1;
            scl_nxt   = 1'b0;
            sda_nxt   = 1'b0;
            delay_nxt = cfg.half_period_delay;
            phase_nxt = PH_STOP_A;
          end else begin
            poll_nxt = poll_r + 1'b1;
          end
        end
        PH_RD_LOW: begin
          scl_nxt   = 1'b1;
          shift_nxt = {shift_r[6:0], q_item.sda_sample};
          phase_nxt = PH_RD_HIGH;
        end
        PH_RD_HIGH: begin
          bit_idx_nxt = bit_idx_r + 1'b1;
          scl_nxt     = 1'b0;
          if (bit_idx_r < LAST_BIT) begin
            phase_nxt = PH_RD_LOW;
          end else begin
            rd_hold_nxt = shift_r;
            sda_nxt     = !ack_choice_r;
            phase_nxt   = PH_RA_LOW;
          end
        end
        PH_RA_LOW: begin
          scl_nxt   = 1'b1;
          phase_nxt = PH_RA_HIGH;
        end
        PH_RA_HIGH: begin
          scl_nxt   = 1'b0;
          phase_nxt = PH_IDLE;
          done      = 1'b1;
        end
        default: begin
          delay_nxt = delay_r;
          phase_nxt = PH_IDLE;
        end
      endcase
      // phases that finish without a new delay keep the counter at zero
      if (phase_nxt == PH_IDLE) begin
        delay_nxt = delay_r;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r      <= PH_IDLE;
      bit_idx_r    <= '0;
      delay_r      <= '0;
      shift_r      <= '0;
      poll_r       <= '0;
      scl_r        <= 1'b1;
      sda_r        <= 1'b1;
      ack_choice_r <= 1'b0;
      fail_r       <= 1'b0;
      rd_hold_r    <= '0;
      o_valid_r    <= 1'b0;
    end else begin
      if (step) begin
        phase_r      <= phase_nxt;
        bit_idx_r    <= bit_idx_nxt;
        delay_r      <= delay_nxt;
        shift_r      <= shift_nxt;
        poll_r       <= poll_nxt;
        scl_r        <= scl_nxt;
        sda_r        <= sda_nxt;
        ack_choice_r <= ack_choice_nxt;
        fail_r       <= fail_nxt;
        rd_hold_r    <= rd_hold_nxt;
      end
      o_valid_r <= step || (o_valid_r && !out_if.ready);
    end
    if (step) begin
      o_scl_r   <= scl_nxt;
      o_sda_r   <= sda_nxt;
      o_busy_r  <= (phase_nxt != PH_IDLE);
      o_done_r  <= done;
      o_rdata_r <= rd_hold_nxt;
      o_fail_r  <= fail_nxt;
    end
  end

  assign out_if.valid       = o_valid_r;
  assign out_if.scl_level   = o_scl_r;
  assign out_if.sda_release = o_sda_r;
  assign out_if.busy_res    = o_busy_r;
  assign out_if.done_res    = o_done_r;
  assign out_if.read_data   = o_rdata_r;
  assign out_if.ack_failed  = o_fail_r;

endmodule

/* sv/i2c_master_bit_engine_core.sv */
// ----------------------------------------------------------------------------
// i2c_master_bit_engine_core
// I2C master bit engine: one tick per item in, one pin/status result out.
//
//   channel   direction  contents
//   in_if     sink       cmd_valid, opcode, write_byte, rd_ack, sda_sample
//   out_if    source     scl_level, sda_release, busy_res, done_res,
//                        read_data, ack_failed
//   APB       slave      half_period_delay (addr 0), ack_poll_limit (addr 4)
//
// One item per cycle sustained while the sink takes results; a tick's result
// passes the front register, then a queue entry, and the engine
// computes and registers the result in the cycle it pops the item.
// The engine updates its phase state once per item, so that per-item
// step sets the rate. Synchronous active-low reset returns pins released,
// phase idle and registers to their defaults. A stalled sink holds the
// result and fills the four-entry queue before the input stalls.
// ----------------------------------------------------------------------------
module i2c_master_bit_engine_core (
  input  logic        clk,
  input  logic        rst_n,
  i2cmbe_in_if.sink   in_if,
  i2cmbe_out_if.source out_if,
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [2:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready
);
  import i2cmbe_pkg::*;

  cfg_t    cfg_r;
  logic    cfg_wr;
  logic    push_valid, push_ready;
  q_item_t push_item;
  logic    pop_valid, pop_ready;
  q_item_t pop_item;

  assign pready = 1'b1;
  assign cfg_wr = psel && penable && pwrite && pready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.half_period_delay <= HALF_PERIOD_RST;
      cfg_r.ack_poll_limit    <= POLL_LIMIT_RST;
    end else if (cfg_wr) begin
      case (paddr[2])
        REG_HALF_PERIOD: cfg_r.half_period_delay <= pwdata[15:0];
        REG_POLL_LIMIT:  cfg_r.ack_poll_limit    <= pwdata[7:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    case (paddr[2])
      REG_HALF_PERIOD: prdata = {16'd0, cfg_r.half_period_delay};
      REG_POLL_LIMIT:  prdata = {24'd0, cfg_r.ack_poll_limit};
      default:         prdata = '0;
    endcase
  end

  i2cmbe_front u_front (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_if      (in_if),
    .push_valid (push_valid),
    .push_ready (push_ready),
    .push_item  (push_item)
  );

  i2cmbe_queue u_queue (
    .clk        (clk),
    .rst_n      (rst_n),
    .push_valid (push_valid),
    .push_ready (push_ready),
    .push_item  (push_item),
    .pop_valid  (pop_valid),
    .pop_ready  (pop_ready),
    .pop_item   (pop_item)
  );

  i2cmbe_engine u_engine (
    .clk     (clk),
    .rst_n   (rst_n),
    .cfg     (cfg_r),
    .q_valid (pop_valid),
    .q_ready (pop_ready),
    .q_item  (pop_item),
    .out_if  (out_if)
  );

endmodule

/* test/i2c_master_bit_engine_core_test.sv */
// ----------------------------------------------------------------------------
// i2c_master_bit_engine_core_test
// Drives clock ticks, with commands and sampled SDA, into the I2C bit engine.
// A scoreboard class steps its own model of the engine for every accepted
// tick and checks the pin and status result that comes out for that tick.
// The run holds back-pressure and gaps on both channels and walks through
// several delay and poll-limit settings, ending with the largest delay.
// ----------------------------------------------------------------------------
module i2c_master_bit_engine_core_test;
  import i2cmbe_pkg::*;

  localparam int CYCLE_LIMIT = 500000;

  typedef enum logic [3:0] {
    PH_IDLE, PH_START_A, PH_START_B, PH_STOP_A, PH_STOP_B, PH_WR_SETUP, PH_WR_HIGH,
    PH_WR_LOW, PH_ACK_WAIT, PH_RD_LOW, PH_RD_HIGH, PH_RA_LOW, PH_RA_HIGH
  } eng_phase_e;

  typedef enum {ACK_NOW, ACK_NEVER, ACK_LATE} ack_plan_e;

  typedef struct packed {
    logic       cmd_valid;
    logic [1:0] opcode;
    logic [7:0] write_byte;
    logic       rd_ack;
    logic       sda_sample;
  } tick_t;

  typedef struct packed {
    logic       scl_level;
    logic       sda_release;
    logic       busy_res;
    logic       done_res;
    logic [7:0] read_data;
    logic       ack_failed;
  } pin_status_t;

  class pin_scoreboard;
    logic [15:0] half_period;
    logic [7:0]  poll_limit;
    eng_phase_e  phase;
    logic [3:0]  bit_idx;
    logic [15:0] wait_left;
    logic [7:0]  shifter;
    logic [7:0]  polls;
    logic [7:0]  read_hold;
    logic        scl;
    logic        sda;
    logic        ack_sel;
    logic        nack;
    pin_status_t pending[$];
    int          mismatches;

    function new();
      half_period = HALF_PERIOD_RST;
      poll_limit  = POLL_LIMIT_RST;
      phase       = PH_IDLE;
      bit_idx     = '0;
      wait_left   = '0;
      shifter     = '0;
      polls       = '0;
      read_hold   = '0;
      scl         = 1'b1;
      sda         = 1'b1;
      ack_sel     = 1'b0;
      nack        = 1'b0;
      mismatches  = 0;
    endfunction

    function void apply_register(logic sel, logic [31:0] data);
      if (sel == REG_HALF_PERIOD) begin
        half_period = data[15:0];
      end else begin
        poll_limit = data[7:0];
      end
    endfunction

    function void enter(eng_phase_e nxt);
      phase     = nxt;
      wait_left = half_period;
    endfunction

    function void shift_out();
      sda     = shifter[7];
      shifter = {shifter[6:0], 1'b0};
    endfunction

    function void note_tick(tick_t t);
      pin_status_t exp;
      logic        done;
      done = 1'b0;
      if (phase == PH_IDLE) begin
        if (t.cmd_valid) begin
          bit_idx = '0;
          polls   = '0;
          case (t.opcode)
            OP_START: begin
              sda = 1'b1;
              scl = 1'b1;
              enter(PH_START_A);
            end
            OP_STOP: begin
              scl = 1'b0;
              sda = 1'b0;
              enter(PH_STOP_A);
            end
            OP_WRITE: begin
              shifter = t.write_byte;
              nack    = 1'b0;
              shift_out();
              enter(PH_WR_SETUP);
            end
            default: begin
              ack_sel = t.rd_ack;
              shifter = '0;
              sda     = 1'b1;
              scl     = 1'b0;
              enter(PH_RD_LOW);
            end
          endcase
        end
      end else if (wait_left != 0) begin
        wait_left = wait_left - 1'b1;
      end else begin
        case (phase)
          PH_START_A: begin
            sda = 1'b0;
            enter(PH_START_B);
          end
          PH_START_B: begin
            scl   = 1'b0;
            phase = PH_IDLE;
            done  = 1'b1;
          end
          PH_STOP_A: begin
            scl = 1'b1;
            sda = 1'b1;
            enter(PH_STOP_B);
          end
          PH_STOP_B: begin
            phase = PH_IDLE;
            done  = 1'b1;
          end
          PH_WR_SETUP: begin
            scl = 1'b1;
            enter(PH_WR_HIGH);
          end
          PH_WR_HIGH: begin
            scl = 1'b0;
            enter(PH_WR_LOW);
          end
          PH_WR_LOW: begin
            bit_idx = bit_idx + 1'b1;
            if (bit_idx < BITS_PER_BYTE) begin
              shift_out();
              enter(PH_WR_SETUP);
            end else begin
              sda   = 1'b1;
              scl   = 1'b1;
              polls = '0;
              enter(PH_ACK_WAIT);
            end
          end
          PH_ACK_WAIT: begin
            if (!t.sda_sample) begin
              scl   = 1'b0;
              nack  = 1'b0;
              phase = PH_IDLE;
              done  = 1'b1;
            end else if (polls >= poll_limit) begin
              // timed out: flag it and close the bus with a stop
              nack = 1'b1;
              scl  = 1'b0;
              sda  = 1'b0;
              enter(PH_STOP_A);
            end else begin
              polls = polls + 1'b1;
            end
          end
          PH_RD_LOW: begin
            scl     = 1'b1;
            shifter = {shifter[6:0], t.sda_sample};
            enter(PH_RD_HIGH);
          end
          PH_RD_HIGH: begin
            bit_idx = bit_idx + 1'b1;
            scl     = 1'b0;
            if (bit_idx < BITS_PER_BYTE) begin
              enter(PH_RD_LOW);
            end else begin
              read_hold = shifter;
              sda       = !ack_sel;
              enter(PH_RA_LOW);
            end
          end
          PH_RA_LOW: begin
            scl = 1'b1;
            enter(PH_RA_HIGH);
          end
          PH_RA_HIGH: begin
            scl   = 1'b0;
            phase = PH_IDLE;
            done  = 1'b1;
          end
          default: begin
            phase = PH_IDLE;
          end
        endcase
      end
      exp.scl_level   = scl;
      exp.sda_release = sda;
      exp.busy_res    = (phase != PH_IDLE);
      exp.done_res    = done;
      exp.read_data   = read_hold;
      exp.ack_failed  = nack;
      pending.push_back(exp);
    endfunction

    function void compare_field(string what, logic [7:0] want, logic [7:0] got);
      if (want !== got) begin
        $display("%0t: %s expected %0h got %0h", $time, what, want, got);
        mismatches++;
      end
    endfunction

    function void check_pins(pin_status_t got);
      pin_status_t exp;
      if (pending.size() == 0) begin
        $display("%0t: result %0h with no tick waiting", $time, got);
        mismatches++;
        return;
      end
      exp = pending.pop_front();
      compare_field("scl_level", exp.scl_level, got.scl_level);
      compare_field("sda_release", exp.sda_release, got.sda_release);
      compare_field("busy_res", exp.busy_res, got.busy_res);
      compare_field("done_res", exp.done_res, got.done_res);
      compare_field("read_data", exp.read_data, got.read_data);
      compare_field("ack_failed", exp.ack_failed, got.ack_failed);
    endfunction
  endclass

  logic        clk = 1'b0;
  logic        rst_n;
  logic        psel;
  logic        penable;
  logic        pwrite;
  logic [2:0]  paddr;
  logic [31:0] pwdata;
  logic [31:0] prdata;
  logic        pready;

  i2cmbe_in_if  in_ch();
  i2cmbe_out_if out_ch();

  pin_scoreboard sb = new();
  int            cycle_count = 0;
  bit            no_idle = 1'b0;
  ack_plan_e     ack_plan = ACK_NOW;
  bit            read_random = 1'b1;
  bit            read_level = 1'b0;
  logic [1:0]    cmd_plan[$];

  i2c_master_bit_engine_core u_dut (
    .clk     (clk),
    .rst_n   (rst_n),
    .in_if   (in_ch),
    .out_if  (out_ch),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready)
  );

  always #10 clk = ~clk;

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count == CYCLE_LIMIT) begin
      $display("i2c_master_bit_engine_core test failed");
      $finish;
    end
  end

  always @(posedge clk) begin
    pin_status_t got;
    if (rst_n && out_ch.valid && out_ch.ready) begin
      got.scl_level   = out_ch.scl_level;
      got.sda_release = out_ch.sda_release;
      got.busy_res    = out_ch.busy_res;
      got.done_res    = out_ch.done_res;
      got.read_data   = out_ch.read_data;
      got.ack_failed  = out_ch.ack_failed;
      sb.check_pins(got);
    end
  end

  // result side: stall for a drawn number of cycles, then take one item
  initial begin
    int stall;
    out_ch.ready <= 1'b0;
    wait (rst_n === 1'b1);
    forever begin
      stall = no_idle ? 0 : $urandom_range(0, 19);
      if (stall != 0) begin
        out_ch.ready <= 1'b0;
        repeat (stall) @(posedge clk);
      end
      out_ch.ready <= 1'b1;
      do @(posedge clk); while (!out_ch.valid);
    end
  end

  function automatic logic pick_sda();
    if (sb.phase == PH_ACK_WAIT) begin
      case (ack_plan)
        ACK_NOW:   return 1'b0;
        ACK_NEVER: return 1'b1;
        default:   return ($urandom_range(0, 3) != 0);
      endcase
    end
    return read_random ? 1'($urandom_range(0, 1)) : read_level;
  endfunction

  function automatic tick_t filler_tick(bit noise);
    tick_t t;
    t.opcode     = 2'($urandom_range(0, 3));
    t.write_byte = 8'($urandom_range(0, 255));
    t.rd_ack     = 1'($urandom_range(0, 1));
    t.sda_sample = pick_sda();
    t.cmd_valid  = noise && ($urandom_range(0, 7) == 0);
    return t;
  endfunction

  function automatic tick_t next_tick();
    tick_t t;
    int    extra;
    if (sb.phase != PH_IDLE) return filler_tick(1'b1);
    t = filler_tick(1'b0);
    if ($urandom_range(0, 3) != 0) begin
      if (cmd_plan.size() == 0) begin
        if ($urandom_range(0, 9) == 0) begin
          cmd_plan.push_back(2'($urandom_range(0, 3)));
        end else begin
          // usual transaction: start, address, some data, stop
          cmd_plan.push_back(OP_START);
          cmd_plan.push_back(OP_WRITE);
          extra = $urandom_range(0, 2);
          repeat (extra) cmd_plan.push_back($urandom_range(0, 1) ? OP_WRITE : OP_READ);
          cmd_plan.push_back(OP_STOP);
        end
      end
      t.cmd_valid = 1'b1;
      t.opcode    = cmd_plan.pop_front();
      if (t.opcode == OP_WRITE) begin
        case ($urandom_range(0, 4))
          0:       ack_plan = ACK_NOW;
          1:       ack_plan = ACK_NEVER;
          default: ack_plan = ACK_LATE;
        endcase
      end
    end
    return t;
  endfunction

  task automatic send_tick(tick_t t);
    int gap;
    in_ch.valid      <= 1'b1;
    in_ch.cmd_valid  <= t.cmd_valid;
    in_ch.opcode     <= t.opcode;
    in_ch.write_byte <= t.write_byte;
    in_ch.rd_ack     <= t.rd_ack;
    in_ch.sda_sample <= t.sda_sample;
    do @(posedge clk); while (!in_ch.ready);
    sb.note_tick(t);
    gap = no_idle ? 0 : $urandom_range(0, 19);
    if (gap != 0) begin
      in_ch.valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
  endtask

  task automatic run_command(logic [1:0] op, logic [7:0] data, logic ack, bit poke_busy);
    tick_t t;
    t            = filler_tick(1'b0);
    t.cmd_valid  = 1'b1;
    t.opcode     = op;
    t.write_byte = data;
    t.rd_ack     = ack;
    send_tick(t);
    if (poke_busy) begin
      // a command while busy must be dropped
      t            = filler_tick(1'b0);
      t.cmd_valid  = 1'b1;
      t.opcode     = OP_STOP;
      send_tick(t);
    end
    while (sb.phase != PH_IDLE) send_tick(filler_tick(1'b0));
  endtask

  task automatic wait_results_done();
    in_ch.valid <= 1'b0;
    while (sb.pending.size() != 0) @(posedge clk);
  endtask

  task automatic write_register(logic sel, logic [31:0] data);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= {sel, 2'b00};
    pwdata  <= data;
    @(posedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    sb.apply_register(sel, data);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    @(posedge clk);
  endtask

  task automatic run_setting(logic [15:0] delay, logic [7:0] limit, int ticks);
    wait_results_done();
    write_register(REG_HALF_PERIOD, {16'd0, delay});
    write_register(REG_POLL_LIMIT, {24'd0, limit});
    no_idle     = ($urandom_range(0, 3) == 0);
    read_random = 1'b1;
    repeat (ticks) send_tick(next_tick());
  endtask

  initial begin
    tick_t t;
    rst_n            <= 1'b0;
    psel             <= 1'b0;
    penable          <= 1'b0;
    pwrite           <= 1'b0;
    paddr            <= '0;
    pwdata           <= '0;
    in_ch.valid      <= 1'b0;
    in_ch.cmd_valid  <= 1'b0;
    in_ch.opcode     <= OP_START;
    in_ch.write_byte <= '0;
    in_ch.rd_ack     <= 1'b0;
    in_ch.sda_sample <= 1'b1;
    repeat (10) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // reset state and default delay
    repeat (2) send_tick(filler_tick(1'b0));
    run_command(OP_START, 8'h00, 1'b0, 1'b0);

    wait_results_done();
    write_register(REG_HALF_PERIOD, 32'd0);
    write_register(REG_POLL_LIMIT, 32'd0);
    run_command(OP_START, 8'h00, 1'b0, 1'b1);
    ack_plan = ACK_NOW;
    run_command(OP_WRITE, 8'h00, 1'b0, 1'b0);
    ack_plan = ACK_NEVER;
    run_command(OP_WRITE, 8'hFF, 1'b0, 1'b0);
    ack_plan = ACK_NOW;
    run_command(OP_WRITE, 8'h80, 1'b1, 1'b0);
    read_random = 1'b0;
    read_level  = 1'b1;
    run_command(OP_READ, 8'hFF, 1'b1, 1'b0);
    read_level  = 1'b0;
    run_command(OP_READ, 8'h5A, 1'b0, 1'b0);
    read_random = 1'b1;
    run_command(OP_STOP, 8'h00, 1'b0, 1'b0);
    t = filler_tick(1'b0);
    send_tick(t);

    run_setting(16'd0, 8'd0, 100);
    run_setting(16'd1, 8'd1, 150);
    run_setting(16'd0, 8'd255, 200);
    run_setting(16'd2, 8'd3, 150);
    run_setting(16'd3, 8'd255, 150);
    run_setting(16'd1, 8'd7, 150);
    run_setting(16'd4, 8'd2, 150);

    // largest delay: just watch it count down from the top
    wait_results_done();
    write_register(REG_HALF_PERIOD, 32'h0000_FFFF);
    no_idle = 1'b1;
    run_setting(16'hFFFF, 8'd255, 0);
    t            = filler_tick(1'b0);
    t.cmd_valid  = 1'b1;
    t.opcode     = OP_START;
    send_tick(t);
    repeat (20) send_tick(filler_tick(1'b1));

    wait_results_done();
    repeat (10) @(posedge clk);
    if (sb.mismatches == 0 && sb.pending.size() == 0) begin
      $display("i2c_master_bit_engine_core test passed");
    end else begin
      $display("i2c_master_bit_engine_core test failed");
    end
    $finish;
  end

endmodule

/* filelist.f */
sv/i2cmbe_pkg.sv
sv/i2cmbe_in_if.sv
sv/i2cmbe_out_if.sv
sv/i2cmbe_front.sv
sv/i2cmbe_queue.sv
sv/i2cmbe_engine.sv
sv/i2c_master_bit_engine_core.sv
test/i2c_master_bit_engine_core_test.sv
